/* design/variable_size_fifo_module_cache_macros.svh */
// Assertion macros for the variable size FIFO module cache.
// Expects aclk and aresetn in the scope of each use.
`ifndef VARIABLE_SIZE_FIFO_MODULE_CACHE_MACROS_SVH
`define VARIABLE_SIZE_FIFO_MODULE_CACHE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VSFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/vsfc_pkg.sv */
// Shared types, constants and helpers for the variable size FIFO module cache.
// No dependencies.
`default_nettype none

package vsfc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_MODULES_DEF = 256;

    localparam int ID_W    = 8;
    localparam int SIZE_W  = 16;
    localparam int FILL_W  = 16;
    localparam int CNT_W   = 32;
    localparam int IDS     = 1 << ID_W;

    localparam logic [SIZE_W-1:0] CAP_RESET = 16'd1024;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 160;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_EVAL,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic load_req;
        logic lookup;
        logic count_hit;
        logic count_big;
        logic evict;
        logic insert;
        logic emit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic big;
        logic need_evict;
        logic out_free;
    } ctrl_sts_t;

    typedef struct packed {
        logic              is_eviction;
        logic [ID_W-1:0]   victim_id;
        logic [SIZE_W-1:0] victim_size;
        logic              hit;
        logic              too_large;
        logic [SIZE_W-1:0] used_after;
        logic [FILL_W-1:0] module_fills;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  eviction_total;
        logic              last;
    } out_rec_t;

    function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
        sat_inc32 = (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [FILL_W-1:0] sat_inc16(input logic [FILL_W-1:0] v);
        sat_inc16 = (v == '1) ? v : v + FILL_W'(1);
    endfunction

endpackage

`default_nettype wire

/* design/vsfc_ctrl.sv */
// Request sequencer for the module cache: lookup, evict loop, insert, final result.
// Depends on vsfc_pkg.
`default_nettype none

module vsfc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire vsfc_pkg::ctrl_sts_t sts,
    output vsfc_pkg::ctrl_cmd_t   cmd
);

    vsfc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vsfc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vsfc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = vsfc_pkg::ST_LOOKUP;
            end
            vsfc_pkg::ST_LOOKUP: begin
                state_next = vsfc_pkg::ST_CHECK;
            end
            vsfc_pkg::ST_CHECK: begin
                if (sts.hit || sts.big) state_next = vsfc_pkg::ST_FINAL;
                else state_next = vsfc_pkg::ST_EVAL;
            end
            vsfc_pkg::ST_EVAL: begin
                if (!sts.need_evict) state_next = vsfc_pkg::ST_FINAL;
            end
            vsfc_pkg::ST_FINAL: begin
                if (sts.out_free) state_next = vsfc_pkg::ST_IDLE;
            end
            default: begin
                state_next = vsfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            vsfc_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            vsfc_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            vsfc_pkg::ST_CHECK: begin
                priority if (sts.hit) begin
                    cmd.count_hit = 1'b1;
                end else if (sts.big) begin
                    cmd.count_big = 1'b1;
                end else begin
                    cmd.count_big = 1'b0;
                end
            end
            vsfc_pkg::ST_EVAL: begin
                if (sts.need_evict) cmd.evict = sts.out_free;
                else cmd.insert = 1'b1;
            end
            vsfc_pkg::ST_FINAL: begin
                cmd.emit_final = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/vsfc_dp.sv */
// Datapath of the module cache: resident queue, fill count table, counters, result register.
// Depends on vsfc_pkg and variable_size_fifo_module_cache_macros.svh.
`default_nettype none

`include "variable_size_fifo_module_cache_macros.svh"

module vsfc_dp #(
    parameter int QUEUE_DEPTH = vsfc_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_MODULES = vsfc_pkg::NUM_MODULES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    input  wire logic [vsfc_pkg::SIZE_W-1:0]  cfg_data,
    input  wire logic [vsfc_pkg::ID_W-1:0]    s_module_id,
    input  wire logic [vsfc_pkg::SIZE_W-1:0]  s_module_size,
    input  wire logic [vsfc_pkg::SIZE_W-1:0]  s_extra_size,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output vsfc_pkg::out_rec_t                m_rec,
    input  wire vsfc_pkg::ctrl_cmd_t          cmd,
    output vsfc_pkg::ctrl_sts_t               sts
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam int FW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
    localparam int IW = vsfc_pkg::ID_W;
    localparam int SW = vsfc_pkg::SIZE_W;

    logic [FW-1:0] mod_tab [vsfc_pkg::IDS];

    for (genvar g = 0; g < vsfc_pkg::IDS; g++) begin : g_mod
        assign mod_tab[g] = FW'(g % NUM_MODULES);
    end

    logic [SW-1:0]    cap_reg;
    logic [IW-1:0]    req_id_reg;
    logic [SW-1:0]    req_size_reg;
    logic [SW-1:0]    req_extra_reg;
    logic [FW-1:0]    fidx_reg;
    logic [SW:0]      se_reg;
    logic             hit_reg, big_reg;
    logic [vsfc_pkg::FILL_W-1:0] fill_rd_reg;
    logic             fill_hit_reg;
    logic [QW-1:0]    head_reg;
    logic [CW-1:0]    count_reg;
    logic [SW-1:0]    used_reg;
    logic [QUEUE_DEPTH-1:0] slot_vld_reg;
    logic [IW-1:0]    id_q [QUEUE_DEPTH];
    logic [SW-1:0]    size_q [QUEUE_DEPTH];
    logic [NUM_MODULES-1:0] fill_vld_reg;
    logic [vsfc_pkg::FILL_W-1:0] fill_mem [NUM_MODULES];
    logic [vsfc_pkg::CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    vsfc_pkg::out_rec_t out_reg;
    logic             out_vld_reg;

    logic [QUEUE_DEPTH-1:0] match;
    logic [IW-1:0]    head_id;
    logic [SW-1:0]    head_size;
    logic [QW-1:0]    head_inc;
    logic [TW-1:0]    tail_sum;
    logic [QW-1:0]    tail;
    logic [SW-1:0]    used_evict, used_base, used_ins;
    logic [SW+1:0]    demand;
    logic [vsfc_pkg::FILL_W-1:0] fill_cur, fill_inc;
    logic [vsfc_pkg::CNT_W-1:0]  evict_cnt_next;
    logic             queue_full;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = slot_vld_reg[i] && (id_q[i] == req_id_reg);
        end
    end

    assign head_id   = id_q[head_reg];
    assign head_size = size_q[head_reg];
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
    assign tail_sum  = TW'(head_reg) + TW'(count_reg);
    assign tail      = (tail_sum >= TW'(QUEUE_DEPTH)) ? QW'(tail_sum - TW'(QUEUE_DEPTH))
                                                      : QW'(tail_sum);
    assign used_evict = (used_reg > head_size) ? used_reg - head_size : '0;
    assign used_base  = (count_reg == '0) ? '0 : used_reg;
    assign used_ins   = used_base + req_size_reg;
    assign demand     = (SW+2)'(se_reg) + (SW+2)'(used_reg);
    assign queue_full = (count_reg == CW'(QUEUE_DEPTH));
    assign fill_cur   = fill_hit_reg ? fill_rd_reg : '0;
    assign fill_inc   = vsfc_pkg::sat_inc16(fill_cur);
    assign evict_cnt_next = vsfc_pkg::sat_inc32(evict_cnt_reg);

    assign sts.hit        = hit_reg;
    assign sts.big        = big_reg;
    assign sts.need_evict = (count_reg != '0) && (queue_full || (demand > (SW+2)'(cap_reg)));
    assign sts.out_free   = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_rec    = out_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= vsfc_pkg::CAP_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            slot_vld_reg  <= '0;
            fill_vld_reg  <= '0;
            fill_hit_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            big_reg       <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            if (cfg_valid) cap_reg <= cfg_data;
            if (cmd.lookup) begin
                hit_reg      <= |match;
                big_reg      <= se_reg > (SW+1)'(cap_reg);
                fill_hit_reg <= fill_vld_reg[fidx_reg];
            end
            if (cmd.count_hit) hit_cnt_reg <= vsfc_pkg::sat_inc32(hit_cnt_reg);
            if (cmd.count_big || cmd.insert) miss_cnt_reg <= vsfc_pkg::sat_inc32(miss_cnt_reg);
            if (cmd.evict) begin
                head_reg               <= head_inc;
                count_reg              <= count_reg - CW'(1);
                used_reg               <= used_evict;
                slot_vld_reg[head_reg] <= 1'b0;
                evict_cnt_reg          <= evict_cnt_next;
            end
            if (cmd.insert) begin
                count_reg              <= count_reg + CW'(1);
                used_reg               <= used_ins;
                slot_vld_reg[tail]     <= 1'b1;
                fill_vld_reg[fidx_reg] <= 1'b1;
                fill_hit_reg           <= 1'b1;
            end
            if (cmd.evict || cmd.emit_final) out_vld_reg <= 1'b1;
            else if (m_tready) out_vld_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_id_reg    <= s_module_id;
            req_size_reg  <= s_module_size;
            req_extra_reg <= s_extra_size;
            fidx_reg      <= mod_tab[s_module_id];
            se_reg        <= (SW+1)'(s_module_size) + (SW+1)'(s_extra_size);
        end
        if (cmd.lookup) begin
            fill_rd_reg <= fill_mem[fidx_reg];
        end
        if (cmd.insert) begin
            id_q[tail]   <= req_id_reg;
            size_q[tail] <= req_size_reg;
            fill_rd_reg  <= fill_inc;
        end
        if (cmd.evict) begin
            out_reg.is_eviction    <= 1'b1;
            out_reg.victim_id      <= head_id;
            out_reg.victim_size    <= head_size;
            out_reg.hit            <= 1'b0;
            out_reg.too_large      <= 1'b0;
            out_reg.used_after     <= used_evict;
            out_reg.module_fills   <= fill_cur;
            out_reg.hit_total      <= hit_cnt_reg;
            out_reg.miss_total     <= miss_cnt_reg;
            out_reg.eviction_total <= evict_cnt_next;
            out_reg.last           <= 1'b0;
        end else if (cmd.emit_final) begin
            out_reg.is_eviction    <= 1'b0;
            out_reg.victim_id      <= '0;
            out_reg.victim_size    <= '0;
            out_reg.hit            <= hit_reg;
            out_reg.too_large      <= big_reg && !hit_reg;
            out_reg.used_after     <= used_reg;
            out_reg.module_fills   <= fill_cur;
            out_reg.hit_total      <= hit_cnt_reg;
            out_reg.miss_total     <= miss_cnt_reg;
            out_reg.eviction_total <= evict_cnt_reg;
            out_reg.last           <= 1'b1;
        end
    end

    // fill count table
    always_ff @(posedge aclk) begin
        if (cmd.insert) fill_mem[fidx_reg] <= fill_inc;
    end

    `VSFC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH), "queue count overflow")
    `VSFC_ASSERT_NOW(a_evict_nonempty, cmd.evict, count_reg != '0, "eviction from empty queue")
    `VSFC_ASSERT_NOW(a_no_overwrite, cmd.evict || cmd.emit_final, !out_vld_reg || m_tready, "result register overwritten")
    `VSFC_ASSERT_NEXT(a_insert_count, cmd.insert, count_reg == $past(count_reg) + CW'(1), "insert did not grow queue")

endmodule

`default_nettype wire

/* design/variable_size_fifo_module_cache.sv */
// Top level of the variable size FIFO module cache: port packing, sequencer and datapath.
// Depends on vsfc_pkg, vsfc_ctrl and vsfc_dp.
`default_nettype none

// One request is taken at a time. A hit or an oversize request goes from its acceptance
// through the lookup and check states to the final state, where its final result enters
// the output register. A miss also evicts up to QUEUE_DEPTH residents: the oldest-first
// eviction loop retires one queue entry a cycle while the output register is free, then the
// module is inserted before the final result. Each eviction report and the final result also
// wait while the output register is held by m_tready low. A new request is accepted while
// the final result still waits in the output register. No clearing pass after reset.
module variable_size_fifo_module_cache #(
    parameter int QUEUE_DEPTH = vsfc_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_MODULES = vsfc_pkg::NUM_MODULES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [vsfc_pkg::SIZE_W-1:0]      cfg_data,   // capacity
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // module_id, module_size, extra_size
    input  wire logic [vsfc_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // victim_id, victim_size, hit, too_large, used_after, module_fills,
    // hit_total, miss_total, eviction_total, zero pad
    output logic [vsfc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                            m_tuser,    // is_eviction
    output logic                                  m_tlast
);

    vsfc_pkg::ctrl_cmd_t cmd;
    vsfc_pkg::ctrl_sts_t sts;
    vsfc_pkg::out_rec_t  rec;

    assign cfg_ready = 1'b1;

    vsfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vsfc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_MODULES (NUM_MODULES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_module_id   (s_tdata[7:0]),
        .s_module_size (s_tdata[23:8]),
        .s_extra_size  (s_tdata[39:24]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_rec         (rec),
        .cmd           (cmd),
        .sts           (sts)
    );

    assign m_tdata = {6'b0, rec.eviction_total, rec.miss_total, rec.hit_total,
                      rec.module_fills, rec.used_after, rec.too_large, rec.hit,
                      rec.victim_size, rec.victim_id};
    assign m_tuser = rec.is_eviction;
    assign m_tlast = rec.last;

endmodule

`default_nettype wire
